@@ design/dhks_pkg.sv @@
// dhks_pkg: shared types and constants for the double hashing key set
// used by the channel interfaces, the register block, the remainder unit and the top level
package dhks_pkg;

   localparam int KEY_W      = 31;
   localparam int REQ_W      = 2;
   localparam int SIZE_REG_W = 13;
   localparam int STEP_W     = 4;
   localparam int STEP_MOD   = 11;
   localparam int CNT_W      = 5;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 13'd4093;

   // request codes
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   // register word indexes
   localparam logic REG_TABLE_SIZE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_STEP,
      ST_READ,
      ST_CHECK,
      ST_RESP
   } st_type;

   typedef struct packed {
      logic start;
      logic key_pass;
   } rem_cmd_type;

endpackage

@@ design/dhks_req_if.sv @@
// dhks_req_if: request channel carrying request code and key
// depends on dhks_pkg
interface dhks_req_if import dhks_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [KEY_W-1:0] key;

   modport source (output valid, req_type, key, input ready);
   modport sink   (input valid, req_type, key, output ready);
endinterface

@@ design/dhks_rsp_if.sv @@
// dhks_rsp_if: response channel carrying found, inserted and status
// depends on dhks_pkg
interface dhks_rsp_if import dhks_pkg::*; ();
   logic valid;
   logic ready;
   logic found;
   logic inserted;
   logic status;

   modport source (output valid, found, inserted, status, input ready);
   modport sink   (input valid, found, inserted, status, output ready);
endinterface

@@ design/dhks_csr.sv @@
// dhks_csr: apb register block holding table_size and giving the clamped slot count
// depends on dhks_pkg
module dhks_csr import dhks_pkg::*; #(
   parameter int TABLE_DEPTH = 4096,
   parameter int SW          = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output logic [SW-1:0]     size
);

   localparam int CW = (SW > SIZE_REG_W) ? SW : SIZE_REG_W;

   logic [SIZE_REG_W-1:0] tsize_ff, tsize_in;
   logic [CW-1:0]         ext;
   logic [CW-1:0]         clamped;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[CSR_AW-1:2] == REG_TABLE_SIZE);

   always_comb begin
      tsize_in = tsize_ff;
      if (wr_en) begin
         tsize_in = pwdata[SIZE_REG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= SIZE_RESET;
      end else begin
         tsize_ff <= tsize_in;
      end
   end

   always_comb begin
      ext = CW'(tsize_ff);
      priority if (ext == '0) begin
         clamped = CW'(1);
      end else if (ext > CW'(TABLE_DEPTH)) begin
         clamped = CW'(TABLE_DEPTH);
      end else begin
         clamped = ext;
      end
   end

   assign size = clamped[SW-1:0];

   always_comb begin
      prdata = '0;
      if (paddr[CSR_AW-1:2] == REG_TABLE_SIZE) begin
         prdata = CSR_DW'(tsize_ff);
      end
   end

endmodule

@@ design/dhks_rem_unit.sv @@
// dhks_rem_unit: bit-serial restoring remainder unit, one dividend bit per cycle
// gives dividend mod divisor and, folded alongside, key mod 11; depends on dhks_pkg
module dhks_rem_unit import dhks_pkg::*; #(
   parameter int SW = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  rem_cmd_type       cmd,
   input  logic [KEY_W-1:0]  dividend,
   input  logic [SW-1:0]     divisor,
   output logic              done,
   output logic [SW-1:0]     rem,
   output logic [STEP_W-1:0] rem11
);

   localparam int FOLD_W = 12;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [KEY_W-1:0]  div_ff, div_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0] r11_ff, r11_in;
   logic [FOLD_W-1:0] fold_ff, fold_in;
   logic [SW:0]       trial;

   // 2**10 is 1 mod 11, so the 10-bit chunks of the key simply add up
   function automatic logic [FOLD_W-1:0] fold_key(input logic [KEY_W-1:0] k);
      return FOLD_W'(k[9:0]) + FOLD_W'(k[19:10]) + FOLD_W'(k[29:20]) +
             FOLD_W'(k[KEY_W-1]);
   endfunction

   // fold once more, then 32 is -1 mod 11, leaving a value of 1 to 64
   function automatic logic [STEP_W-1:0] mod11_fold(input logic [FOLD_W-1:0] s);
      logic [10:0] x;
      logic [6:0]  y;
      logic [6:0]  r;
      x = 11'(s[9:0]) + 11'(s[FOLD_W-1:10]);
      y = 7'(x[4:0]) + 7'(3 * STEP_MOD) - 7'(x[10:5]);
      priority if (y >= 7'(5 * STEP_MOD)) begin
         r = y - 7'(5 * STEP_MOD);
      end else if (y >= 7'(4 * STEP_MOD)) begin
         r = y - 7'(4 * STEP_MOD);
      end else if (y >= 7'(3 * STEP_MOD)) begin
         r = y - 7'(3 * STEP_MOD);
      end else if (y >= 7'(2 * STEP_MOD)) begin
         r = y - 7'(2 * STEP_MOD);
      end else if (y >= 7'(STEP_MOD)) begin
         r = y - 7'(STEP_MOD);
      end else begin
         r = y;
      end
      return r[STEP_W-1:0];
   endfunction

   assign trial = {rem_ff, div_ff[KEY_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      r11_in  = r11_ff;
      fold_in = fold_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.key_pass ? CNT_W'(KEY_W) : CNT_W'(STEP_W);
         div_in  = dividend;
         rem_in  = '0;
         if (cmd.key_pass) begin
            fold_in = fold_key(dividend);
         end
      end else if (busy_ff) begin
         div_in = {div_ff[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = SW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[SW-1:0];
         end
         r11_in = mod11_fold(fold_ff);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      r11_ff  <= r11_in;
      fold_ff <= fold_in;
   end

   assign done  = done_ff;
   assign rem   = rem_ff;
   assign rem11 = r11_ff;

endmodule

@@ design/double_hash_key_set.sv @@
// double_hash_key_set: open-addressed key set with double hashing, top level
// depends on dhks_pkg, dhks_req_if, dhks_rsp_if, dhks_csr and dhks_rem_unit

// One request at a time. A lookup or insert first runs the shared bit-serial remainder
// unit over the key to get the home slot and key mod 11, then over the probe step to reduce
// it by the table size; each probe is then a registered table read followed by a compare.
// A clear request sweeps the table one slot a cycle, and the same sweep runs after reset
// before the first request is taken; register writes are taken throughout.
// A finished response sits in an output register, so the next request is taken while it waits.
module double_hash_key_set import dhks_pkg::*; #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   dhks_req_if.sink          req_chan,
   dhks_rsp_if.source        rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = $clog2(TABLE_DEPTH + 1);

   st_type st_ff, st_in;

   logic [SW-1:0]     size;
   rem_cmd_type       rem_cmd;
   logic [KEY_W-1:0]  rem_dividend;
   logic              rem_done;
   logic [SW-1:0]     rem;
   logic [STEP_W-1:0] rem11;
   logic [STEP_W-1:0] step;

   logic [REQ_W-1:0]  op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     stepm_ff;
   logic [SW-1:0]     probes_ff, probes_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              clr_resp_ff, clr_resp_in;
   logic              res_found_ff, res_found_in;
   logic              res_ins_ff, res_ins_in;
   logic              res_full_ff, res_full_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_found_ff, rsp_ins_ff, rsp_full_ff;

   // table word: valid bit over the stored key
   logic [KEY_W:0]    mem [TABLE_DEPTH];
   logic [KEY_W:0]    rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [KEY_W:0]    mem_wdata;

   logic              req_acc;
   logic              slot_empty;
   logic              slot_hit;
   logic              last_probe;
   logic              clr_last;
   logic              rsp_load;
   logic [SW:0]       pos_sum;
   logic [SW:0]       pos_wrap;

   dhks_csr #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SW          (SW)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .size    (size)
   );

   dhks_rem_unit #(
      .SW (SW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rem_cmd),
      .dividend (rem_dividend),
      .divisor  (size),
      .done     (rem_done),
      .rem      (rem),
      .rem11    (rem11)
   );

   assign req_acc    = req_chan.valid && req_chan.ready;
   assign step       = rem11 + STEP_W'(1);
   assign slot_empty = !rd_ff[KEY_W];
   assign slot_hit   = rd_ff[KEY_W] && (rd_ff[KEY_W-1:0] == key_ff);
   assign last_probe = (probes_ff == size - SW'(1));
   assign clr_last   = (clr_ff == AW'(TABLE_DEPTH - 1));
   assign rsp_load   = (st_ff == ST_RESP) && (!rsp_vld_ff || rsp_chan.ready);

   // next probe slot: step already reduced below size, so one compare and subtract
   assign pos_sum  = (SW+1)'(pos_ff) + (SW+1)'(stepm_ff);
   assign pos_wrap = (pos_sum >= (SW+1)'(size)) ? pos_sum - (SW+1)'(size) : pos_sum;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               priority if (req_chan.req_type == REQ_CLEAR) begin
                  st_in = ST_CLEAR;
               end else if (req_chan.req_type == REQ_LOOKUP ||
                            req_chan.req_type == REQ_INSERT) begin
                  st_in = ST_DIV;
               end else begin
                  st_in = ST_RESP;
               end
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               st_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (rem_done) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_empty || slot_hit || last_probe) begin
               st_in = ST_RESP;
            end else begin
               st_in = ST_READ;
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               st_in = clr_resp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_chan.ready = 1'b0;
      rem_cmd        = '0;
      rem_dividend   = req_chan.key;
      mem_we         = 1'b0;
      mem_waddr      = pos_ff;
      mem_wdata      = {1'b1, key_ff};
      pos_in         = pos_ff;
      probes_in      = probes_ff;
      clr_in         = clr_ff;
      clr_resp_in    = clr_resp_ff;
      res_found_in   = res_found_ff;
      res_ins_in     = res_ins_ff;
      res_full_in    = res_full_ff;
      unique case (st_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            res_found_in   = 1'b0;
            res_ins_in     = 1'b0;
            res_full_in    = 1'b0;
            clr_in         = '0;
            clr_resp_in    = 1'b1;
            if (req_acc && (req_chan.req_type == REQ_LOOKUP ||
                            req_chan.req_type == REQ_INSERT)) begin
               rem_cmd.start    = 1'b1;
               rem_cmd.key_pass = 1'b1;
            end
         end
         ST_DIV: begin
            rem_dividend = {step, (KEY_W-STEP_W)'(0)};
            if (rem_done) begin
               pos_in        = rem[AW-1:0];
               rem_cmd.start = 1'b1;
            end
         end
         ST_STEP: begin
            probes_in = '0;
         end
         ST_READ: begin
         end
         ST_CHECK: begin
            priority if (slot_empty) begin
               if (op_ff == REQ_INSERT) begin
                  mem_we     = 1'b1;
                  res_ins_in = 1'b1;
               end
            end else if (slot_hit) begin
               res_found_in = 1'b1;
            end else if (last_probe) begin
               res_full_in = 1'b1;
            end else begin
               pos_in    = pos_wrap[AW-1:0];
               probes_in = probes_ff + SW'(1);
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_last ? '0 : clr_ff + AW'(1);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_CLEAR;
         clr_ff      <= '0;
         clr_resp_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         st_ff       <= st_in;
         clr_ff      <= clr_in;
         clr_resp_ff <= clr_resp_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff  <= req_chan.req_type;
         key_ff <= req_chan.key;
      end
      if (st_ff == ST_STEP && rem_done) begin
         stepm_ff <= rem;
      end
      pos_ff       <= pos_in;
      probes_ff    <= probes_in;
      res_found_ff <= res_found_in;
      res_ins_ff   <= res_ins_in;
      res_full_ff  <= res_full_in;
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_ins_ff   <= res_ins_ff;
         rsp_full_ff  <= res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[pos_ff];
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.inserted = rsp_ins_ff;
   assign rsp_chan.status   = rsp_full_ff;

`ifndef SYNTHESIS
   a_occupy_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_wdata[KEY_W]) |-> (st_ff == ST_CHECK && op_ff == REQ_INSERT && slot_empty))
      else $error("slot occupied outside an insert into an empty slot");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ($countones({rsp_found_ff, rsp_ins_ff, rsp_full_ff}) <= 1))
      else $error("response reports more than one outcome");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHECK) |-> ((SW+1)'(pos_ff) < (SW+1)'(size) && probes_ff < size))
      else $error("probe slot or probe count beyond table size");

   a_lookup_no_write: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHECK && op_ff == REQ_LOOKUP) |-> !mem_we)
      else $error("lookup wrote the table");

   a_clear_sweep_advances: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR && !clr_last) |=> (st_ff == ST_CLEAR && clr_ff == $past(clr_ff) + AW'(1)))
      else $error("clearing sweep skipped or stalled");
`endif

endmodule
